@@ rtl/hair_cell_receptor_potential_defines.svh @@
// Assertion macros used by the checker file.
`ifndef HAIR_CELL_RECEPTOR_POTENTIAL_DEFINES_SVH
`define HAIR_CELL_RECEPTOR_POTENTIAL_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define HCRP_ASSERT_SAME(label, clk, rst, cond, expect_now, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expect_now)) \
    else $error(msg);

// Check that a condition implies another in the following cycle.
`define HCRP_ASSERT_NEXT(label, clk, rst, cond, expect_next, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expect_next)) \
    else $error(msg);

`endif

@@ rtl/hcrp_pkg.sv @@
`default_nettype none

package hcrp_pkg;

  // Field widths
  localparam int SAMPLE_W  = 32;
  localparam int CHAN_W    = 6;
  localparam int CONST_W   = 31;
  localparam int DT_W      = 17;
  localparam int FRAC_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 31;

  // Divider widths: 64-bit dividend, 33-bit divisor, quotient bounded by g
  localparam int NUM_W  = 64;
  localparam int DEN_W  = 33;
  localparam int QUOT_W = 31;

  // Default channel count
  localparam int NUM_CHANNELS_DEF = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERM_A    = 2'd0,
    CFG_PERM_B    = 2'd1,
    CFG_RELEASE_G = 2'd2,
    CFG_DT_TM     = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REST_MUL,
    ST_REST_DIV,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_PROD,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

@@ rtl/hcrp_in_if.sv @@
`default_nettype none

interface hcrp_in_if import hcrp_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic        [CHAN_W-1:0]   channel_index;
  logic                       restart;

  modport source (output valid, output sample_value, output channel_index,
                  output restart, input ready);
  modport sink   (input valid, input sample_value, input channel_index,
                  input restart, output ready);
endinterface

`default_nettype wire

@@ rtl/hcrp_out_if.sv @@
`default_nettype none

interface hcrp_out_if import hcrp_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] potential_out;
  logic        [CHAN_W-1:0]   channel_out;

  modport source (output valid, output potential_out, output channel_out,
                  input ready);
  modport sink   (input valid, input potential_out, input channel_out,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/hcrp_ram.sv @@
`default_nettype none

module hcrp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             re,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/hcrp_div.sv @@
`default_nettype none

// Restoring radix-2 divider, one quotient bit per cycle. The caller
// guarantees the quotient fits QUOT_W bits and the divisor is nonzero.
module hcrp_div import hcrp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [NUM_W-1:0]  num,
  input  wire logic [DEN_W-1:0]  den,
  output logic                   done,
  output logic [QUOT_W-1:0]      quot
);

  localparam int CNT_W = $clog2(QUOT_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den_q;
  logic [QUOT_W-1:0] nq;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;

  // Trial subtract of the shifted remainder
  always_comb begin
    trial = {rem, nq[QUOT_W-1]};
    diff  = trial - {1'b0, den_q};
  end

  // Step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QUOT_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num[NUM_W-1:QUOT_W];
      nq    <= num[QUOT_W-1:0];
      den_q <= den;
    end else if (busy) begin
      rem <= diff[DEN_W] ? trial[DEN_W-1:0] : diff[DEN_W-1:0];
      nq  <= {nq[QUOT_W-2:0], ~diff[DEN_W]};
    end
  end

  assign quot = nq;

endmodule

`default_nettype wire

@@ rtl/hair_cell_receptor_potential.sv @@
// Multichannel hair-cell receptor potential. Each input word carries one
// Q16.16 sample for one channel; the block forms the permeability
// k = g*(s+A)/(s+A+B) (zero when s+A is not positive), moves that channel's
// low-pass state toward k by dt_over_tm and returns the saturated new state.
// Channel state lives in a one-port-read, one-port-write RAM; a restart flag
// loads the resting value g*A/(A+B) first. Items are handled one at a time:
// an accepted word passes the prepare, multiply, bit-serial divide, product
// and finish states; the finish state loads the result word into the output
// register once it is free, and no new word is taken until the block is
// back in idle. A finished result waits in the output register while the
// next item is worked on. After reset and after every configuration write
// the block computes the resting value through the same divider, with
// ready held low. Channel numbers at or above NUM_CHANNELS wrap modulo
// NUM_CHANNELS; channel_out echoes the input channel.
`default_nettype none

module hair_cell_receptor_potential import hcrp_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  hcrp_in_if.sink                    stim,
  hcrp_out_if.source                 resp,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ADDR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int NCH    = 2 ** CHAN_W;
  localparam int SUM_W  = SAMPLE_W + 2;
  localparam int DIFF_W = CONST_W + 2;
  localparam int PROD_W = DIFF_W + DT_W + 1;
  localparam int TERM_W = PROD_W - FRAC_W;
  localparam int YS_W   = TERM_W + 1;

  typedef logic [NCH-1:0][ADDR_W-1:0] slot_lut_t;

  // Channel to RAM entry, channel modulo NUM_CHANNELS
  function automatic slot_lut_t build_slot_lut();
    slot_lut_t   lut;
    int unsigned v;
    for (int c = 0; c < NCH; c++) begin
      v = c;
      for (int k = 0; k < NCH; k++) begin
        if (v >= NUM_CHANNELS) begin
          v = v - NUM_CHANNELS;
        end
      end
      lut[c] = ADDR_W'(v);
    end
    return lut;
  endfunction

  localparam slot_lut_t SLOT_LUT = build_slot_lut();

  state_t state, state_next;

  // Configuration
  logic [CONST_W-1:0] a_q, b_q, g_q;
  logic [DT_W-1:0]    dt_q;
  logic               dirty;
  logic [QUOT_W-1:0]  rest_q;

  // Item registers
  logic signed [SAMPLE_W-1:0] s_q;
  logic [CHAN_W-1:0]          chan_q;
  logic                       restart_q;
  logic [ADDR_W-1:0]          slot_q;
  logic signed [SUM_W-1:0]    sum_q;
  logic signed [SAMPLE_W-1:0] y_q;
  logic signed [DIFF_W-1:0]   diff_q;
  logic signed [PROD_W-1:0]   prod_q;

  // Output register
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_pot;
  logic [CHAN_W-1:0]          out_chan;

  // Control
  logic accept, div_start, ram_re, fin_go;
  logic div_done;
  logic [QUOT_W-1:0]  div_quot;
  logic [NUM_W-1:0]   div_num;
  logic [DEN_W-1:0]   div_den;
  logic [SAMPLE_W-1:0] ram_rdata;
  logic signed [SAMPLE_W-1:0] y_new;

  // Datapath combinational terms
  logic                     sum_pos;
  logic [NUM_W-1:0]         gs_prod, ga_prod;
  logic [DEN_W-1:0]         sb_den, ab_den;
  logic signed [TERM_W-1:0] term;
  logic signed [YS_W-1:0]   y_sum;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (dirty) begin
          state_next = ST_REST_MUL;
        end else if (stim.valid) begin
          state_next = ST_PREP;
        end
      end
      ST_REST_MUL: state_next = ST_REST_DIV;
      ST_REST_DIV: begin
        if (div_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_PREP: state_next = ST_MUL;
      ST_MUL:  state_next = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_PROD;
        end
      end
      ST_PROD: state_next = ST_FIN;
      ST_FIN: begin
        if (!out_valid || resp.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    stim.ready = 1'b0;
    div_start  = 1'b0;
    fin_go     = 1'b0;
    unique case (state)
      ST_IDLE:     stim.ready = !dirty;
      ST_REST_MUL: div_start  = 1'b1;
      ST_MUL:      div_start  = 1'b1;
      ST_FIN:      fin_go     = !out_valid || resp.ready;
      ST_REST_DIV, ST_PREP, ST_DIV, ST_PROD: ;
      default: ;
    endcase
  end

  assign accept = stim.valid && stim.ready;
  assign ram_re = accept;

  // Configuration writes; any write marks the resting value stale
  always_ff @(posedge clk) begin
    if (rst) begin
      a_q   <= '0;
      b_q   <= '0;
      g_q   <= '0;
      dt_q  <= '0;
      dirty <= 1'b1;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index_t'(cfg_index))
          CFG_PERM_A:    a_q  <= cfg_data;
          CFG_PERM_B:    b_q  <= cfg_data;
          CFG_RELEASE_G: g_q  <= cfg_data;
          CFG_DT_TM:     dt_q <= cfg_data[DT_W-1:0];
          default: ;
        endcase
        dirty <= 1'b1;
      end else if (state == ST_REST_MUL) begin
        dirty <= 1'b0;
      end
    end
  end

  // Hold the resting value
  always_ff @(posedge clk) begin
    if (state == ST_REST_DIV && div_done) begin
      rest_q <= div_quot;
    end
  end

  // Dividend and divisor for both uses
  always_comb begin
    sum_pos = !sum_q[SUM_W-1] && (sum_q[SUM_W-2:0] != '0);
    gs_prod = g_q * sum_q[DEN_W-1:0];
    ga_prod = g_q * a_q;
    sb_den  = sum_q[DEN_W-1:0] + {2'b00, b_q};
    ab_den  = {2'b00, a_q} + {2'b00, b_q};
    if (state == ST_REST_MUL) begin
      div_num = ga_prod;
      div_den = (ab_den == '0) ? DEN_W'(1) : ab_den;
    end else if (sum_pos) begin
      div_num = gs_prod;
      div_den = sb_den;
    end else begin
      div_num = '0;
      div_den = DEN_W'(1);
    end
  end

  // Item datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      s_q       <= stim.sample_value;
      chan_q    <= stim.channel_index;
      restart_q <= stim.restart;
      slot_q    <= SLOT_LUT[stim.channel_index];
    end
    if (state == ST_PREP) begin
      sum_q <= {{2{s_q[SAMPLE_W-1]}}, s_q} + {3'b000, a_q};
      y_q   <= restart_q ? {1'b0, rest_q} : ram_rdata;
    end
    if (state == ST_DIV && div_done) begin
      diff_q <= $signed({2'b00, div_quot}) - $signed({y_q[SAMPLE_W-1], y_q});
    end
    if (state == ST_PROD) begin
      prod_q <= diff_q * $signed({1'b0, dt_q});
    end
  end

  // Floor shift, add, saturate
  always_comb begin
    term  = prod_q[PROD_W-1:FRAC_W];
    y_sum = {{(YS_W-SAMPLE_W){y_q[SAMPLE_W-1]}}, y_q} + {term[TERM_W-1], term};
    if (y_sum[YS_W-1:SAMPLE_W-1] == '0 || y_sum[YS_W-1:SAMPLE_W-1] == '1) begin
      y_new = y_sum[SAMPLE_W-1:0];
    end else if (y_sum[YS_W-1]) begin
      y_new = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      y_new = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_go) begin
      out_valid <= 1'b1;
    end else if (resp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_pot  <= y_new;
      out_chan <= chan_q;
    end
  end

  assign resp.valid         = out_valid;
  assign resp.potential_out = out_pot;
  assign resp.channel_out   = out_chan;

  hcrp_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (NUM_CHANNELS)
  ) u_state_ram (
    .clk     (clk),
    .we      (fin_go),
    .wr_addr (slot_q),
    .wr_data (y_new),
    .re      (ram_re),
    .rd_addr (SLOT_LUT[stim.channel_index]),
    .rd_data (ram_rdata)
  );

  hcrp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

endmodule

`default_nettype wire

@@ rtl/hcrp_checker.sv @@
`default_nettype none
`include "hair_cell_receptor_potential_defines.svh"

module hcrp_checker import hcrp_pkg::*; (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       stim_valid,
  input wire logic                       stim_ready,
  input wire logic                       resp_valid,
  input wire logic                       resp_ready,
  input wire logic signed [SAMPLE_W-1:0] resp_potential,
  input wire logic [CHAN_W-1:0]          resp_chan,
  input wire logic                       cfg_we
);

  logic stim_take;

  assign stim_take = stim_valid && stim_ready;

  // A waiting result word stays until taken
  `HCRP_ASSERT_NEXT(a_resp_hold, clk, rst, resp_valid && !resp_ready, resp_valid, "result dropped while stalled")
  // A stalled result word keeps its payload
  `HCRP_ASSERT_NEXT(a_resp_stable, clk, rst, resp_valid && !resp_ready, $stable(resp_potential) && $stable(resp_chan), "result payload changed while stalled")
  // One item at a time: no second word right behind an accepted one
  `HCRP_ASSERT_NEXT(a_one_at_a_time, clk, rst, stim_take, !stim_ready, "input taken back to back")
  // No result can appear in the cycle after an input word is taken
  `HCRP_ASSERT_NEXT(a_min_latency, clk, rst, stim_take, !$rose(resp_valid), "result too early")
  // A configuration write stalls input while the resting value is redone
  `HCRP_ASSERT_NEXT(a_cfg_stall, clk, rst, cfg_we, !stim_ready, "input ready right after config write")

endmodule

bind hair_cell_receptor_potential hcrp_checker u_hcrp_checker (
  .clk            (clk),
  .rst            (rst),
  .stim_valid     (stim.valid),
  .stim_ready     (stim.ready),
  .resp_valid     (resp.valid),
  .resp_ready     (resp.ready),
  .resp_potential (resp.potential_out),
  .resp_chan      (resp.channel_out),
  .cfg_we         (cfg_we)
);

`default_nettype wire
